// ----- src/tgc_pkg.sv -----
// Shared types, constants and codes of the touch gesture classifier.
`timescale 1ns / 1ps

package tgc_pkg;

    // Field widths
    localparam int RAW_W    = 11;
    localparam int LOG_W    = 12;
    localparam int TRAVEL_W = 13;
    localparam int TIME_W   = 32;
    localparam int TAB_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Number of navigation tabs in the bottom band, 1 to 8
    localparam int NAV_TABS = 4;
    localparam logic [TAB_W-1:0] TAB_MAX = TAB_W'(NAV_TABS - 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME_MS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_TOP         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_BOTTOM      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOGICAL_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH        = 3'd6;

    // Configuration reset values
    localparam logic [10:0] RST_SCROLL_THRESHOLD = 11'd48;
    localparam logic [15:0] RST_HOLD_TIME_MS     = 16'd280;
    localparam logic [11:0] RST_PANEL_WIDTH      = 12'd1024;
    localparam logic [10:0] RST_BAND_TOP         = 11'd802;
    localparam logic [11:0] RST_BAND_BOTTOM      = 12'd918;
    localparam logic [11:0] RST_LOGICAL_WIDTH    = 12'd768;
    localparam logic [11:0] RST_TAB_WIDTH        = 12'd192;

    // Tab divider: the dividend is a non-negative logical x
    localparam int DIVIDEND_W = RAW_W;
    localparam int DIVISOR_W  = LOG_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    typedef enum logic [1:0] {
        G_TAP  = 2'd0,
        G_UP   = 2'd1,
        G_DOWN = 2'd2
    } gesture_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_CLASS,
        S_TIME,
        S_BAND,
        S_DIV,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } tgc_div_ctrl_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } tgc_div_stat_t;

endpackage

// ----- src/tgc_sample_if.sv -----
// Touch sample channel: valid, ready and one panel sample.
`timescale 1ns / 1ps

interface tgc_sample_if;
    import tgc_pkg::*;

    logic              valid;
    logic              ready;
    logic              touched;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output touched, output raw_x, output raw_y,
                    output now_ms, input ready);
    modport sink   (input valid, input touched, input raw_x, input raw_y,
                    input now_ms, output ready);
endinterface

// ----- src/tgc_result_if.sv -----
// Gesture result channel: valid, ready and one classified gesture.
`timescale 1ns / 1ps

interface tgc_result_if;
    import tgc_pkg::*;

    logic                       valid;
    logic                       ready;
    gesture_t                   gesture;
    logic                       tab_valid;
    logic [TAB_W-1:0]           tab_index;
    logic [RAW_W-1:0]           start_raw_x;
    logic [RAW_W-1:0]           start_raw_y;
    logic signed [LOG_W-1:0]    start_x;
    logic signed [LOG_W-1:0]    start_y;
    logic signed [LOG_W-1:0]    end_x;
    logic signed [LOG_W-1:0]    end_y;
    logic signed [TRAVEL_W-1:0] travel_y;

    modport source (output valid, output gesture, output tab_valid, output tab_index,
                    output start_raw_x, output start_raw_y, output start_x,
                    output start_y, output end_x, output end_y, output travel_y,
                    input ready);
    modport sink   (input valid, input gesture, input tab_valid, input tab_index,
                    input start_raw_x, input start_raw_y, input start_x,
                    input start_y, input end_x, input end_y, input travel_y,
                    output ready);
endinterface

// ----- src/touch_gesture_classifier.sv -----
// Top level of the tap and swipe classifier for a rotated touch panel.
//
//   Channel   Dir  Handshake             Payload
//   sample    in   valid / ready         touched, raw_x, raw_y, now_ms
//   result    out  valid / ready         gesture, tab fields, start/end points, travel_y
//   cfg       in   cfg_we, no ready      cfg_index selects register, cfg_data
//
// A release with nothing pending or a touch after its gesture went out ends at the map
// step; a held touch short of the hold time stops after the time step; a swipe goes
// from class to emit; a tap outside the tab band passes the band step, and a tap in
// the band also waits for the serial tab divider. The sample side is ready only
// while the sequencer idles. A finished result waits in the output register; the next
// sample is still taken, and only its own result waits for the register to empty.
// Reset clears the tracking state and loads the configuration defaults.
`timescale 1ns / 1ps

module touch_gesture_classifier (
    input  logic                              clk,
    input  logic                              rst_n,
    tgc_sample_if.sink                        sample,
    tgc_result_if.source                      result,
    input  logic                              cfg_we,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tgc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tgc_pkg::*;

    state_t state_reg, state_next;

    // Configuration
    logic [10:0] thr_reg;
    logic [15:0] hold_reg;
    logic [11:0] pw_reg;
    logic [10:0] btop_reg;
    logic [11:0] bbot_reg;
    logic [11:0] lw_reg;
    logic [11:0] tw_reg;

    // Captured sample
    logic              touched_reg;
    logic [RAW_W-1:0]  rx_reg;
    logic [RAW_W-1:0]  ry_reg;
    logic [TIME_W-1:0] now_reg;

    // Gesture tracking state
    logic                    tracking_reg, tracking_next;
    logic                    emitted_reg, emitted_next;
    logic [TIME_W-1:0]       stime_reg, stime_next;
    logic [RAW_W-1:0]        srx_reg, srx_next;
    logic [RAW_W-1:0]        sry_reg, sry_next;
    logic signed [LOG_W-1:0] sx_reg, sx_next;
    logic signed [LOG_W-1:0] sy_reg, sy_next;
    logic signed [LOG_W-1:0] lx_reg, lx_next;
    logic signed [LOG_W-1:0] ly_reg, ly_next;

    // Result being built
    gesture_t         kind_reg, kind_next;
    logic             tabv_reg, tabv_next;
    logic [TAB_W-1:0] tabidx_reg, tabidx_next;

    // Output register
    logic                       ovalid_reg, ovalid_next;
    logic                       oload;
    gesture_t                   ogest_reg;
    logic                       otabv_reg;
    logic [TAB_W-1:0]           otabidx_reg;
    logic [RAW_W-1:0]           osrx_reg, osry_reg;
    logic signed [LOG_W-1:0]    osx_reg, osy_reg, oex_reg, oey_reg;
    logic signed [TRAVEL_W-1:0] otravel_reg;

    // Datapath terms
    logic signed [LOG_W-1:0]    lx_calc, ly_calc;
    logic signed [TRAVEL_W-1:0] dy, th, neg_th;
    gesture_t                   kind_calc;
    logic [TIME_W-1:0]          elapsed;
    logic                       hold_met;
    logic                       in_band;
    logic                       sample_fire;
    tgc_div_ctrl_t              div_ctrl;
    tgc_div_stat_t              div_stat;

    assign sample.ready = (state_reg == S_IDLE);
    assign sample_fire  = sample.valid && sample.ready;

    // Rotation: logical x is raw y, logical y mirrors raw x across the panel width.
    assign lx_calc = {1'b0, ry_reg};
    assign ly_calc = pw_reg - 12'd1 - {1'b0, rx_reg};

    assign dy     = {ly_reg[LOG_W-1], ly_reg} - {sy_reg[LOG_W-1], sy_reg};
    assign th     = {2'b00, thr_reg};
    assign neg_th = -th;

    always_comb
    begin
        if (dy <= neg_th)
            kind_calc = G_UP;
        else if (dy >= th)
            kind_calc = G_DOWN;
        else
            kind_calc = G_TAP;
    end

    assign elapsed  = now_reg - stime_reg;
    assign hold_met = elapsed >= {16'd0, hold_reg};

    // Start x is never negative, since it comes from an 11-bit raw y.
    assign in_band = !sx_reg[LOG_W-1] && (sx_reg < lw_reg)
                  && !sy_reg[LOG_W-1] && (sy_reg[LOG_W-2:0] >= btop_reg)
                  && (sy_reg < bbot_reg);

    assign div_ctrl.start    = (state_reg == S_BAND) && in_band && (tw_reg != '0);
    assign div_ctrl.dividend = sx_reg[DIVIDEND_W-1:0];
    assign div_ctrl.divisor  = tw_reg;

    tgc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (sample.valid)
                    state_next = S_MAP;
            S_MAP:
                if (!touched_reg)
                    state_next = (tracking_reg && !emitted_reg) ? S_CLASS : S_IDLE;
                else
                    state_next = (tracking_reg && emitted_reg) ? S_IDLE : S_CLASS;
            S_CLASS:
                if (kind_calc != G_TAP)
                    state_next = S_EMIT;
                else
                    state_next = touched_reg ? S_TIME : S_BAND;
            S_TIME:
                state_next = hold_met ? S_BAND : S_IDLE;
            S_BAND:
                state_next = div_ctrl.start ? S_DIV : S_EMIT;
            S_DIV:
                if (div_stat.done)
                    state_next = S_EMIT;
            S_EMIT:
                if (!ovalid_reg || result.ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Register updates per state
    always_comb
    begin
        tracking_next = tracking_reg;
        emitted_next  = emitted_reg;
        stime_next    = stime_reg;
        srx_next      = srx_reg;
        sry_next      = sry_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        lx_next       = lx_reg;
        ly_next       = ly_reg;
        kind_next     = kind_reg;
        tabv_next     = tabv_reg;
        tabidx_next   = tabidx_reg;
        oload         = 1'b0;
        case (state_reg)
            S_MAP:
                if (!touched_reg)
                begin
                    tracking_next = 1'b0;
                    emitted_next  = 1'b0;
                end
                else
                begin
                    if (!tracking_reg)
                    begin
                        tracking_next = 1'b1;
                        emitted_next  = 1'b0;
                        stime_next    = now_reg;
                        srx_next      = rx_reg;
                        sry_next      = ry_reg;
                        sx_next       = lx_calc;
                        sy_next       = ly_calc;
                    end
                    lx_next = lx_calc;
                    ly_next = ly_calc;
                end
            S_CLASS:
            begin
                kind_next   = kind_calc;
                tabv_next   = 1'b0;
                tabidx_next = '0;
                // A swipe while held ends tracking at once.
                if (touched_reg && (kind_calc != G_TAP))
                begin
                    emitted_next  = 1'b1;
                    tracking_next = 1'b0;
                end
            end
            S_TIME:
                if (hold_met)
                    emitted_next = 1'b1;
            S_BAND:
            begin
                tabv_next = in_band;
                if (in_band && (tw_reg == '0))
                    tabidx_next = TAB_MAX;
            end
            S_DIV:
                if (div_stat.done)
                begin
                    if (div_stat.quotient > DIVIDEND_W'(TAB_MAX))
                        tabidx_next = TAB_MAX;
                    else
                        tabidx_next = div_stat.quotient[TAB_W-1:0];
                end
            S_EMIT:
                oload = !ovalid_reg || result.ready;
            default:
                oload = 1'b0;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg && !result.ready;
        if (oload)
            ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ovalid_reg   <= 1'b0;
            tracking_reg <= 1'b0;
            emitted_reg  <= 1'b0;
            stime_reg    <= '0;
            srx_reg      <= '0;
            sry_reg      <= '0;
            sx_reg       <= '0;
            sy_reg       <= '0;
            lx_reg       <= '0;
            ly_reg       <= '0;
            kind_reg     <= G_TAP;
            tabv_reg     <= 1'b0;
            tabidx_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ovalid_reg   <= ovalid_next;
            tracking_reg <= tracking_next;
            emitted_reg  <= emitted_next;
            stime_reg    <= stime_next;
            srx_reg      <= srx_next;
            sry_reg      <= sry_next;
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
            lx_reg       <= lx_next;
            ly_reg       <= ly_next;
            kind_reg     <= kind_next;
            tabv_reg     <= tabv_next;
            tabidx_reg   <= tabidx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= RST_SCROLL_THRESHOLD;
            hold_reg <= RST_HOLD_TIME_MS;
            pw_reg   <= RST_PANEL_WIDTH;
            btop_reg <= RST_BAND_TOP;
            bbot_reg <= RST_BAND_BOTTOM;
            lw_reg   <= RST_LOGICAL_WIDTH;
            tw_reg   <= RST_TAB_WIDTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCROLL_THRESHOLD: thr_reg  <= cfg_data[10:0];
                CFG_HOLD_TIME_MS:     hold_reg <= cfg_data;
                CFG_PANEL_WIDTH:      pw_reg   <= cfg_data[11:0];
                CFG_BAND_TOP:         btop_reg <= cfg_data[10:0];
                CFG_BAND_BOTTOM:      bbot_reg <= cfg_data[11:0];
                CFG_LOGICAL_WIDTH:    lw_reg   <= cfg_data[11:0];
                CFG_TAB_WIDTH:        tw_reg   <= cfg_data[11:0];
                default:              thr_reg  <= thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            touched_reg <= sample.touched;
            rx_reg      <= sample.raw_x;
            ry_reg      <= sample.raw_y;
            now_reg     <= sample.now_ms;
        end
        if (oload)
        begin
            ogest_reg   <= kind_reg;
            otabv_reg   <= tabv_reg;
            otabidx_reg <= tabidx_reg;
            osrx_reg    <= srx_reg;
            osry_reg    <= sry_reg;
            osx_reg     <= sx_reg;
            osy_reg     <= sy_reg;
            oex_reg     <= lx_reg;
            oey_reg     <= ly_reg;
            otravel_reg <= dy;
        end
    end

    assign result.valid       = ovalid_reg;
    assign result.gesture     = ogest_reg;
    assign result.tab_valid   = otabv_reg;
    assign result.tab_index   = otabidx_reg;
    assign result.start_raw_x = osrx_reg;
    assign result.start_raw_y = osry_reg;
    assign result.start_x     = osx_reg;
    assign result.start_y     = osy_reg;
    assign result.end_x       = oex_reg;
    assign result.end_y       = oey_reg;
    assign result.travel_y    = otravel_reg;

    // A new result only ever comes out of the emit step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result valid rose outside the emit step");

    // Only taps carry a tab hit, and the index is clamped.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.tab_valid |->
            (result.gesture == G_TAP) && (result.tab_index <= TAB_MAX))
        else $error("tab hit on a swipe or tab index out of range");

    // The sequencer leaves the divide step on the cycle after the divider finishes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && div_stat.done |=> (state_reg == S_EMIT))
        else $error("divide step not left after divider finished");

    // No sample is taken while the divider is still working.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> !div_stat.busy)
        else $error("sample side ready while divider busy");

endmodule

// ----- src/tgc_div.sv -----
// Restoring divider, one quotient bit per cycle, for the tab hit index.
`timescale 1ns / 1ps

module tgc_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tgc_pkg::tgc_div_ctrl_t ctrl,
    output tgc_pkg::tgc_div_stat_t stat
);
    import tgc_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // The dividend shifts out of the top of quo_reg while quotient bits enter below.
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = ctrl.dividend;
            dvs_next  = ctrl.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the touch gesture classifier with a built-in gesture predictor.
`timescale 1ns / 1ps

module tb_top;
    import tgc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        gesture_t                   gesture;
        logic                       tab_valid;
        logic [TAB_W-1:0]           tab_index;
        logic [RAW_W-1:0]           start_raw_x;
        logic [RAW_W-1:0]           start_raw_y;
        logic signed [LOG_W-1:0]    start_x;
        logic signed [LOG_W-1:0]    start_y;
        logic signed [LOG_W-1:0]    end_x;
        logic signed [LOG_W-1:0]    end_y;
        logic signed [TRAVEL_W-1:0] travel_y;
    } gesture_rec_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tgc_sample_if sample_ch ();
    tgc_result_if result_ch ();

    touch_gesture_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the configuration registers.
    logic [10:0] cur_thr;
    logic [15:0] cur_hold;
    logic [11:0] cur_pw;
    logic [10:0] cur_btop;
    logic [11:0] cur_bbot;
    logic [11:0] cur_lw;
    logic [11:0] cur_tw;

    // Predictor copy of the tracking state.
    bit                      trk;
    bit                      already_sent;
    logic [TIME_W-1:0]       t_start;
    logic [RAW_W-1:0]        s_rx;
    logic [RAW_W-1:0]        s_ry;
    logic signed [LOG_W-1:0] s_lx;
    logic signed [LOG_W-1:0] s_ly;
    logic signed [LOG_W-1:0] e_lx;
    logic signed [LOG_W-1:0] e_ly;

    gesture_rec_t pending_gestures[$];
    gesture_rec_t want;
    int           errors;
    int           samples_sent;
    int           burst_left;
    bit           gaps_on;
    int           cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic gesture_t classify_travel(int dy);
        int th;
        th = int'(cur_thr);
        if (dy <= -th)
            return G_UP;
        if (dy >= th)
            return G_DOWN;
        return G_TAP;
    endfunction

    function automatic void push_gesture(gesture_t g, int dy);
        gesture_rec_t r;
        int           idx;
        int           sx_i;
        int           sy_i;
        sx_i = s_lx;
        sy_i = s_ly;
        idx = 0;
        r.tab_valid = 1'b0;
        if (g == G_TAP && sx_i >= 0 && sx_i < int'(cur_lw) &&
            sy_i >= int'(cur_btop) && sy_i < int'(cur_bbot))
        begin
            r.tab_valid = 1'b1;
            // A zero tab width lands on the last tab.
            idx = (cur_tw == 12'd0) ? NAV_TABS - 1 : sx_i / int'(cur_tw);
            if (idx > NAV_TABS - 1)
                idx = NAV_TABS - 1;
        end
        r.gesture     = g;
        r.tab_index   = TAB_W'(idx);
        r.start_raw_x = s_rx;
        r.start_raw_y = s_ry;
        r.start_x     = s_lx;
        r.start_y     = s_ly;
        r.end_x       = e_lx;
        r.end_y       = e_ly;
        r.travel_y    = TRAVEL_W'(dy);
        pending_gestures.push_back(r);
    endfunction

    function automatic void track_sample(logic t, logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
                                         logic [TIME_W-1:0] now);
        logic signed [LOG_W-1:0] lx;
        logic signed [LOG_W-1:0] ly;
        logic [LOG_W-1:0]        mirror;
        logic [TIME_W-1:0]       elapsed;
        int                      dy;
        bit                      fire;
        gesture_t                g;
        if (!t)
        begin
            fire = trk && !already_sent;
            dy = int'(e_ly) - int'(s_ly);
            trk = 1'b0;
            already_sent = 1'b0;
            if (fire)
                push_gesture(classify_travel(dy), dy);
            return;
        end
        lx = {1'b0, ry};
        mirror = cur_pw - 12'd1 - {1'b0, rx};
        ly = mirror;
        if (!trk)
        begin
            trk = 1'b1;
            already_sent = 1'b0;
            t_start = now;
            s_rx = rx;
            s_ry = ry;
            s_lx = lx;
            s_ly = ly;
        end
        e_lx = lx;
        e_ly = ly;
        if (already_sent)
            return;
        dy = int'(e_ly) - int'(s_ly);
        g = classify_travel(dy);
        elapsed = now - t_start;
        if (g == G_TAP && elapsed < {16'd0, cur_hold})
            return;
        already_sent = 1'b1;
        push_gesture(g, dy);
        if (g != G_TAP)
            trk = 1'b0;
    endfunction

    function automatic void compare_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want_v, got_v);
        end
    endfunction

    // Result checker: each transfer is matched against the oldest predicted gesture.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_gestures.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual gesture %h",
                         $time, result_ch.gesture);
            end
            else
            begin
                want = pending_gestures.pop_front();
                compare_field("gesture", 32'(want.gesture), 32'(result_ch.gesture));
                compare_field("tab_valid", 32'(want.tab_valid), 32'(result_ch.tab_valid));
                compare_field("tab_index", 32'(want.tab_index), 32'(result_ch.tab_index));
                compare_field("start_raw_x", 32'(want.start_raw_x), 32'(result_ch.start_raw_x));
                compare_field("start_raw_y", 32'(want.start_raw_y), 32'(result_ch.start_raw_y));
                compare_field("start_x", 32'(want.start_x), 32'(result_ch.start_x));
                compare_field("start_y", 32'(want.start_y), 32'(result_ch.start_y));
                compare_field("end_x", 32'(want.end_x), 32'(result_ch.end_x));
                compare_field("end_y", 32'(want.end_y), 32'(result_ch.end_y));
                compare_field("travel_y", 32'(want.travel_y), 32'(result_ch.travel_y));
            end
        end
    end

    // Receiver: switches between free-flowing, random and long-stall patterns.
    initial
    begin
        int mode;
        int left;
        int stall_cnt;
        result_ch.ready = 1'b0;
        mode = 0;
        left = 0;
        stall_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(50, 300);
            end
            left--;
            case (mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= 1'($urandom_range(0, 1));
                2:
                begin
                    if (stall_cnt == 0)
                        stall_cnt = $urandom_range(2, 14);
                    stall_cnt--;
                    result_ch.ready <= (stall_cnt < 2);
                end
                default: result_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Drives one sample, waits for its transfer and updates the prediction.
    task automatic send_sample(input logic t, input logic [RAW_W-1:0] rx,
                               input logic [RAW_W-1:0] ry, input logic [TIME_W-1:0] now);
        sample_ch.valid   <= 1'b1;
        sample_ch.touched <= t;
        sample_ch.raw_x   <= rx;
        sample_ch.raw_y   <= ry;
        sample_ch.now_ms  <= now;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        track_sample(t, rx, ry, now);
        samples_sent++;
        if (gaps_on && burst_left == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
        else if (burst_left > 0)
        begin
            burst_left--;
        end
    endtask

    // Lets every predicted gesture arrive and the sequencer go idle.
    task automatic quiesce();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_gestures.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_SCROLL_THRESHOLD: cur_thr  = val[10:0];
            CFG_HOLD_TIME_MS:     cur_hold = val;
            CFG_PANEL_WIDTH:      cur_pw   = val[11:0];
            CFG_BAND_TOP:         cur_btop = val[10:0];
            CFG_BAND_BOTTOM:      cur_bbot = val[11:0];
            CFG_LOGICAL_WIDTH:    cur_lw   = val[11:0];
            CFG_TAB_WIDTH:        cur_tw   = val[11:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [15:0] thr, input logic [15:0] hold,
                                 input logic [15:0] pw, input logic [15:0] btop,
                                 input logic [15:0] bbot, input logic [15:0] lw,
                                 input logic [15:0] tw);
        quiesce();
        write_reg(CFG_SCROLL_THRESHOLD, thr);
        write_reg(CFG_HOLD_TIME_MS, hold);
        write_reg(CFG_PANEL_WIDTH, pw);
        write_reg(CFG_BAND_TOP, btop);
        write_reg(CFG_BAND_BOTTOM, bbot);
        write_reg(CFG_LOGICAL_WIDTH, lw);
        write_reg(CFG_TAB_WIDTH, tw);
    endtask

    function automatic logic [TIME_W-1:0] next_delay();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1, 2: return {16'd0, cur_hold} + 32'($urandom_range(0, 3));
            default: return 32'($urandom_range(0, int'(cur_hold) / 2 + 1));
        endcase
    endfunction

    // One touch from press to release, starting in the tab band a third of the time.
    task automatic play_gesture();
        int                rx_i;
        int                ry_i;
        int                ly_i;
        int                span;
        int                jump;
        int                ry_top;
        logic [TIME_W-1:0] stamp;
        stamp = $urandom;
        if ($urandom_range(0, 2) == 0)
        begin
            span = int'(cur_bbot) - int'(cur_btop);
            ly_i = int'(cur_btop) + ((span > 0) ? int'($urandom_range(0, span - 1)) : 0);
            rx_i = (int'(cur_pw) - 1 - ly_i) & 32'h7FF;
        end
        else
        begin
            rx_i = $urandom_range(0, 2047);
        end
        ry_top = int'(cur_lw) + int'(cur_lw) / 4;
        if (ry_top > 2047)
            ry_top = 2047;
        ry_i = $urandom_range(0, ry_top);
        send_sample(1'b1, RAW_W'(rx_i), RAW_W'(ry_i), stamp);
        jump = int'(cur_thr) + int'(cur_thr) / 2 + 1;
        repeat ($urandom_range(0, 6))
        begin
            stamp += next_delay();
            rx_i += int'($urandom_range(0, 2 * jump)) - jump;
            if (rx_i < 0)
                rx_i = 0;
            if (rx_i > 2047)
                rx_i = 2047;
            if ($urandom_range(0, 3) == 0)
                ry_i = $urandom_range(0, 2047);
            send_sample(1'b1, RAW_W'(rx_i), RAW_W'(ry_i), stamp);
        end
        if ($urandom_range(0, 7) != 0)
        begin
            stamp += next_delay();
            send_sample(1'b0, RAW_W'($urandom), RAW_W'($urandom), stamp);
        end
    endtask

    task automatic run_random_phase(input int count);
        int first;
        first = samples_sent;
        while (samples_sent - first < count)
        begin
            if ($urandom_range(0, 9) < 8)
                play_gesture();
            else
                send_sample(1'($urandom_range(0, 1)), RAW_W'($urandom), RAW_W'($urandom),
                            $urandom);
        end
    endtask

    task automatic pick_random_settings();
        int pw;
        int bt;
        int lw;
        pw = $urandom_range(256, 2048);
        bt = $urandom_range(0, pw - 1);
        lw = $urandom_range(64, 2048);
        load_settings(16'($urandom_range(1, 200)), 16'($urandom_range(1, 600)), 16'(pw),
                      16'(bt), 16'(bt + int'($urandom_range(1, 300))), 16'(lw),
                      16'(lw / int'($urandom_range(1, 8))));
    endtask

    // Reset values: a stationary touch taps once the hold time has passed.
    task automatic test_hold_tap();
        send_sample(1'b1, 11'd173, 11'd500, 32'd1000);
        send_sample(1'b1, 11'd173, 11'd500, 32'd1279);
        send_sample(1'b1, 11'd173, 11'd500, 32'd1280);
        send_sample(1'b0, 11'd173, 11'd500, 32'd1290);
    endtask

    task automatic test_release_tap();
        send_sample(1'b1, 11'd173, 11'd700, 32'd2000);
        send_sample(1'b0, 11'd0, 11'd0, 32'd2010);
    endtask

    // Swipes end tracking, so a touch still held afterwards starts over.
    task automatic test_swipes();
        send_sample(1'b1, 11'd500, 11'd100, 32'd3000);
        send_sample(1'b1, 11'd452, 11'd100, 32'd3010);
        send_sample(1'b1, 11'd452, 11'd100, 32'd3020);
        send_sample(1'b0, 11'd452, 11'd100, 32'd3030);
        send_sample(1'b1, 11'd500, 11'd100, 32'd4000);
        send_sample(1'b1, 11'd548, 11'd100, 32'd4005);
        send_sample(1'b0, 11'd548, 11'd100, 32'd4010);
    endtask

    // Full-scale coordinates and a hold that spans the time stamp wrap.
    task automatic test_field_extremes();
        send_sample(1'b1, 11'd2047, 11'd2047, 32'hFFFF_FF00);
        send_sample(1'b1, 11'd2047, 11'd2047, 32'h0000_0018);
        send_sample(1'b0, 11'd2047, 11'd2047, 32'hFFFF_FFFF);
        send_sample(1'b1, 11'd0, 11'd0, 32'd0);
        send_sample(1'b1, 11'd2047, 11'd0, 32'd5);
        send_sample(1'b0, 11'd0, 11'd0, 32'd6);
    endtask

    task automatic test_corner_settings();
        // Zero threshold: zero travel already counts as a swipe up.
        load_settings(16'd0, RST_HOLD_TIME_MS, RST_PANEL_WIDTH, RST_BAND_TOP,
                      RST_BAND_BOTTOM, RST_LOGICAL_WIDTH, RST_TAB_WIDTH);
        send_sample(1'b1, 11'd100, 11'd100, 32'd10);
        send_sample(1'b0, 11'd100, 11'd100, 32'd11);
        // Zero hold time taps at once; zero tab width picks the last tab.
        load_settings(16'd2047, 16'd0, RST_PANEL_WIDTH, RST_BAND_TOP,
                      RST_BAND_BOTTOM, RST_LOGICAL_WIDTH, 16'd0);
        send_sample(1'b1, 11'd173, 11'd500, 32'd20);
        send_sample(1'b0, 11'd173, 11'd500, 32'd21);
        // Oversized panel width wraps logical y; a one-pixel tab forces the clamp.
        load_settings(RST_SCROLL_THRESHOLD, RST_HOLD_TIME_MS, 16'd4095, 16'd0,
                      16'd2048, 16'd2048, 16'd1);
        send_sample(1'b1, 11'd2047, 11'd500, 32'd0);
        send_sample(1'b0, 11'd2047, 11'd500, 32'd1);
        send_sample(1'b1, 11'd0, 11'd10, 32'd0);
        send_sample(1'b0, 11'd0, 11'd10, 32'd1);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0: load_settings(RST_SCROLL_THRESHOLD, RST_HOLD_TIME_MS, RST_PANEL_WIDTH,
                                 RST_BAND_TOP, RST_BAND_BOTTOM, RST_LOGICAL_WIDTH,
                                 RST_TAB_WIDTH);
                2: load_settings(16'd2047, 16'd65535, 16'd4095, 16'd2047, 16'd4095,
                                 16'd4095, 16'd4095);
                3: load_settings(16'd1, 16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1);
                default: pick_random_settings();
            endcase
            gaps_on = (phase != 1);
            run_random_phase(92);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SCROLL_THRESHOLD;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.touched = 1'b0;
        sample_ch.raw_x = '0;
        sample_ch.raw_y = '0;
        sample_ch.now_ms = '0;
        cur_thr = RST_SCROLL_THRESHOLD;
        cur_hold = RST_HOLD_TIME_MS;
        cur_pw = RST_PANEL_WIDTH;
        cur_btop = RST_BAND_TOP;
        cur_bbot = RST_BAND_BOTTOM;
        cur_lw = RST_LOGICAL_WIDTH;
        cur_tw = RST_TAB_WIDTH;
        trk = 1'b0;
        already_sent = 1'b0;
        t_start = '0;
        s_rx = '0;
        s_ry = '0;
        s_lx = '0;
        s_ly = '0;
        e_lx = '0;
        e_ly = '0;
        errors = 0;
        samples_sent = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hold_tap();
        test_release_tap();
        test_swipes();
        test_field_extremes();
        test_corner_settings();
        test_random_traffic();
        quiesce();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
